// ===== rtl/seglcd_pkg.sv =====
// ----------------------------------------------------------------------------
// seglcd_pkg
// Shared types, codes and font tables for the segment LCD serial writer.
// ----------------------------------------------------------------------------
package seglcd_pkg;

  // Request modes
  localparam logic [2:0] MODE_CMD   = 3'd0;
  localparam logic [2:0] MODE_RAW   = 3'd1;
  localparam logic [2:0] MODE_ICON  = 3'd2;
  localparam logic [2:0] MODE_DIGIT = 3'd3;
  localparam logic [2:0] MODE_GLYPH = 3'd4;

  // Frame IDs sent ahead of each frame
  localparam logic [2:0] ID_CMD   = 3'b100;
  localparam logic [2:0] ID_WRITE = 3'b101;

  localparam logic [5:0] GLYPH_BLANK    = 6'd36;
  localparam logic [5:0] LOWER_ROW_BASE = 6'd13;

  // Bit positions inside a frame
  localparam logic [3:0] CMD_LAST_BIT   = 4'd11;
  localparam logic [3:0] WRITE_LAST_BIT = 4'd12;
  localparam logic [4:0] SECOND_FRAME   = 5'd13;
  localparam logic [4:0] TWO_FRAME_LAST = 5'd25;

  localparam int QUEUE_DEPTH = 2;

  // One queued request for the serializer
  typedef struct packed {
    logic       is_cmd;
    logic       two_frames;
    logic [5:0] addr;
    logic [3:0] nib0;
    logic [3:0] nib1;
    logic [7:0] cmd;
  } frame_desc_t;

  // Queue status seen by the front end
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // First nibble address of a digit position
  function automatic logic [5:0] digit_addr(input logic [2:0] pos);
    logic [5:0] offs;
    offs = {3'b000, pos[1:0], 1'b0};
    return pos[2] ? (LOWER_ROW_BASE + offs) : offs;
  endfunction

  // Segment pair {second, first} for a glyph; blank and unused give zero
  function automatic logic [7:0] font_segs(input logic [5:0] glyph);
    logic [7:0] s;
    case (glyph)
      6'd0:  s = 8'hAF;
      6'd1:  s = 8'hA0;
      6'd2:  s = 8'h6D;
      6'd3:  s = 8'hE9;
      6'd4:  s = 8'hE2;
      6'd5:  s = 8'hCB;
      6'd6:  s = 8'hCF;
      6'd7:  s = 8'hA1;
      6'd8:  s = 8'hEF;
      6'd9:  s = 8'hEB;
      6'd10: s = 8'hE7;
      6'd11: s = 8'hCE;
      6'd12: s = 8'h0F;
      6'd13: s = 8'hEC;
      6'd14: s = 8'h4F;
      6'd15: s = 8'h47;
      6'd16: s = 8'hCF;
      6'd17: s = 8'hE6;
      6'd18: s = 8'hA0;
      6'd19: s = 8'hE8;
      6'd20: s = 8'h66;
      6'd21: s = 8'h0E;
      6'd22: s = 8'hA5;
      6'd23: s = 8'hC4;
      6'd24: s = 8'hAF;
      6'd25: s = 8'h67;
      6'd26: s = 8'hE3;
      6'd27: s = 8'h44;
      6'd28: s = 8'hCB;
      6'd29: s = 8'h4E;
      6'd30: s = 8'h8C;
      6'd31: s = 8'hAE;
      6'd32: s = 8'hAC;
      6'd33: s = 8'hA6;
      6'd34: s = 8'hEB;
      6'd35: s = 8'h69;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/seglcd_front.sv =====
// ----------------------------------------------------------------------------
// seglcd_front
// Accepts requests, keeps the display memory shadow and turns each request
// into a frame descriptor for the serializer queue.
// ----------------------------------------------------------------------------
module seglcd_front
  import seglcd_pkg::*;
#(
  parameter int MEM_NIBBLES = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // mode[2:0] address[7:3] value[15:8] icon_bit[17:16] icon_on[18]
  // digit_pos[21:19] seg_low[25:22] seg_high[29:26] dot[30] glyph[36:31]
  input  logic [39:0]   s_tdata,
  output logic          q_push,
  output frame_desc_t   q_desc,
  input  queue_status_t q_stat
);

  localparam int AW = (MEM_NIBBLES > 1) ? $clog2(MEM_NIBBLES) : 1;
  localparam logic [6:0] DEPTH = 7'(MEM_NIBBLES);

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_WR2} state_t;

  state_t state;

  // Request fields
  logic [2:0] in_mode;
  logic [4:0] in_address;
  logic [2:0] in_pos;
  assign in_mode    = s_tdata[2:0];
  assign in_address = s_tdata[7:3];
  assign in_pos     = s_tdata[21:19];

  // Captured request
  logic [2:0] mode_q;
  logic [4:0] address_q;
  logic [7:0] value_q;
  logic [1:0] icon_bit_q;
  logic       icon_on_q;
  logic [3:0] seg_low_q;
  logic [3:0] seg_high_q;
  logic       dot_q;
  logic [5:0] glyph_q;
  logic [5:0] a0_q;

  // Shadow memory with per-entry valid bits
  logic [3:0]             mem [MEM_NIBBLES];
  logic [MEM_NIBBLES-1:0] valid;
  logic [3:0]             rd_nib;
  logic                   rd_hit;
  logic [5:0]             rd_addr;
  logic [3:0]             keep;

  logic       accept;
  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);

  // Icon reads its own nibble, digits read the shared icon nibble
  assign rd_addr = (in_mode == MODE_ICON) ? {1'b0, in_address}
                                          : digit_addr(in_pos) + 6'd1;
  assign keep    = rd_hit ? rd_nib : 4'h0;

  // Descriptor build
  frame_desc_t desc;
  frame_desc_t desc_q;
  logic        go;
  logic [3:0]  mask;
  logic [7:0]  segs;

  always_comb begin
    desc     = '0;
    go       = 1'b0;
    mask     = 4'b0001 << icon_bit_q;
    segs     = font_segs(glyph_q);
    desc.cmd = value_q;
    case (mode_q)
      MODE_CMD: begin
        go          = 1'b1;
        desc.is_cmd = 1'b1;
      end
      MODE_RAW: begin
        go        = 1'b1;
        desc.addr = {1'b0, address_q};
        desc.nib0 = value_q[3:0];
      end
      MODE_ICON: begin
        go        = 1'b1;
        desc.addr = {1'b0, address_q};
        desc.nib0 = icon_on_q ? (keep | mask) : (keep & ~mask);
      end
      MODE_DIGIT: begin
        go              = 1'b1;
        desc.two_frames = 1'b1;
        desc.addr       = a0_q;
        desc.nib0       = seg_low_q;
        desc.nib1       = seg_high_q | {3'b000, dot_q | keep[0]};
      end
      MODE_GLYPH: begin
        go              = (glyph_q <= GLYPH_BLANK);
        desc.two_frames = 1'b1;
        desc.addr       = a0_q;
        desc.nib0       = segs[3:0];
        desc.nib1       = segs[7:4] | {3'b000, keep[0]};
      end
      default: go = 1'b0;
    endcase
  end

  assign q_push = (state == ST_EXEC) && go && !q_stat.full;
  assign q_desc = desc;

  // Shadow write port
  logic       wr_en;
  logic [5:0] wr_addr;
  logic [3:0] wr_data;
  logic       wr_in_range;

  always_comb begin
    wr_addr     = (state == ST_EXEC) ? desc.addr : desc_q.addr + 6'd1;
    wr_data     = (state == ST_EXEC) ? desc.nib0 : desc_q.nib1;
    wr_in_range = ({1'b0, wr_addr} < DEPTH);
    wr_en       = ((q_push && !desc.is_cmd) || (state == ST_WR2)) && wr_in_range;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
    if (accept) begin
      rd_nib <= mem[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr[AW-1:0]] <= 1'b1;
      end
      if (accept) begin
        rd_hit <= ({1'b0, rd_addr} < DEPTH) && valid[rd_addr[AW-1:0]];
      end
    end
  end

  // Sequencer: capture, classify and push, second shadow write
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (!go) begin
            state <= ST_IDLE;
          end else if (!q_stat.full) begin
            state <= desc.two_frames ? ST_WR2 : ST_IDLE;
          end
        end
        ST_WR2: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q     <= in_mode;
      address_q  <= in_address;
      value_q    <= s_tdata[15:8];
      icon_bit_q <= s_tdata[17:16];
      icon_on_q  <= s_tdata[18];
      seg_low_q  <= s_tdata[25:22];
      seg_high_q <= s_tdata[29:26];
      dot_q      <= s_tdata[30];
      glyph_q    <= s_tdata[36:31];
      a0_q       <= digit_addr(in_pos);
    end
    if (state == ST_EXEC) begin
      desc_q <= desc;
    end
  end

endmodule

// ===== rtl/seglcd_queue.sv =====
// ----------------------------------------------------------------------------
// seglcd_queue
// Short descriptor queue between the front end and the serializer.
// ----------------------------------------------------------------------------
module seglcd_queue
  import seglcd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  frame_desc_t   push_desc,
  input  logic          pop,
  output frame_desc_t   pop_desc,
  output queue_status_t stat
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  frame_desc_t   slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign stat.full  = (count == CNT_FULL);
  assign stat.empty = (count == '0);
  assign pop_desc   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/seglcd_serializer.sv =====
// ----------------------------------------------------------------------------
// seglcd_serializer
// Takes frame descriptors from the queue and emits their bits one per
// transaction through a registered output stage.
// ----------------------------------------------------------------------------
module seglcd_serializer
  import seglcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  frame_desc_t q_desc,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  // data_bit[0], zero fill [7:1]
  output logic [7:0]  m_tdata,
  // frame_end[0]
  output logic [0:0]  m_tuser,
  output logic        m_tlast
);

  frame_desc_t desc;
  logic        busy;
  logic [4:0]  idx;
  logic        adv;

  assign adv   = !m_tvalid || m_tready;
  assign q_pop = !busy && !q_empty;

  // Current bit
  logic       second;
  logic [4:0] li5;
  logic [3:0] li;
  logic [5:0] addr;
  logic [3:0] nib;
  logic [3:0] sel;
  logic       bit_val;
  logic       frame_end;
  logic       last_bit;
  logic [4:0] last_idx;

  always_comb begin
    second = !desc.is_cmd && (idx >= SECOND_FRAME);
    li5    = second ? (idx - SECOND_FRAME) : idx;
    li     = li5[3:0];
    addr   = second ? (desc.addr + 6'd1) : desc.addr;
    nib    = second ? desc.nib1 : desc.nib0;
    sel    = 4'd0;
    if (desc.is_cmd) begin
      if (li < 4'd3) begin
        sel     = 4'd2 - li;
        bit_val = ID_CMD[sel[1:0]];
      end else if (li < CMD_LAST_BIT) begin
        sel     = 4'd10 - li;
        bit_val = desc.cmd[sel[2:0]];
      end else begin
        bit_val = 1'b0;
      end
      frame_end = (li == CMD_LAST_BIT);
      last_idx  = {1'b0, CMD_LAST_BIT};
    end else begin
      if (li < 4'd3) begin
        sel     = 4'd2 - li;
        bit_val = ID_WRITE[sel[1:0]];
      end else if (li < 4'd9) begin
        sel     = 4'd8 - li;
        bit_val = addr[sel[2:0]];
      end else begin
        sel     = li - 4'd9;
        bit_val = nib[sel[1:0]];
      end
      frame_end = (li == WRITE_LAST_BIT);
      last_idx  = desc.two_frames ? TWO_FRAME_LAST : {1'b0, WRITE_LAST_BIT};
    end
    last_bit = (idx == last_idx);
  end

  // Control: load, step, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy && adv) begin
        idx <= idx + 5'd1;
        if (last_bit) begin
          busy <= 1'b0;
        end
      end
      if (adv) begin
        m_tvalid <= busy;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      desc <= q_desc;
    end
    if (busy && adv) begin
      m_tdata <= {7'b0000000, bit_val};
      m_tuser <= frame_end;
      m_tlast <= last_bit;
    end
  end

endmodule

// ===== rtl/segment_lcd_serial_writer_top.sv =====
// ----------------------------------------------------------------------------
// segment_lcd_serial_writer_top
// Serial bit writer for a three-wire segment LCD controller.
// ----------------------------------------------------------------------------
// Each request becomes the bit sequence of the controller's write protocol,
// one output transaction per write strobe: a command gives 12 bits, a raw or
// icon write 13, a digit or glyph write 26 (two frames). The serializer emits
// one bit per cycle while the output is not stalled, and loads the next
// descriptor only once the last bit of a request is out; that bit loop sets
// the rate. The front end handles one request at a time (digit and glyph
// pass through a second shadow write state, as their two shadow nibbles share
// one write port) and runs ahead of the serializer through a two-entry queue.
// Requests with an unused mode or a glyph above blank produce no bits. The
// display shadow is cleared at reset by per-entry valid bits, so no clearing pass is needed.
module segment_lcd_serial_writer_top
  import seglcd_pkg::*;
#(
  parameter int MEM_NIBBLES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // mode[2:0] address[7:3] value[15:8] icon_bit[17:16] icon_on[18]
  // digit_pos[21:19] seg_low[25:22] seg_high[29:26] dot[30] glyph[36:31]
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // data_bit[0], zero fill [7:1]
  output logic [7:0]  m_tdata,
  // frame_end[0]
  output logic [0:0]  m_tuser,
  output logic        m_tlast
);

  logic          q_push;
  logic          q_pop;
  frame_desc_t   push_desc;
  frame_desc_t   pop_desc;
  queue_status_t q_stat;

  seglcd_front #(
    .MEM_NIBBLES(MEM_NIBBLES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .q_push  (q_push),
    .q_desc  (push_desc),
    .q_stat  (q_stat)
  );

  seglcd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_desc(push_desc),
    .pop      (q_pop),
    .pop_desc (pop_desc),
    .stat     (q_stat)
  );

  seglcd_serializer u_ser (
    .clk     (clk),
    .rst     (rst),
    .q_desc  (pop_desc),
    .q_empty (q_stat.empty),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

`ifndef SYNTHESIS
  // Front end never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_stat.full))
    else $error("descriptor pushed into full queue");

  // Serializer never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_stat.empty))
    else $error("descriptor popped from empty queue");

  // The final bit of a request always closes a frame
  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser[0])
    else $error("request ended inside a frame");
`endif

endmodule

// ===== verif/segment_lcd_serial_writer_checker.sv =====
// ----------------------------------------------------------------------------
// segment_lcd_serial_writer_checker
// Watches both streams of the LCD serial writer and checks every bit it emits.
// ----------------------------------------------------------------------------
// Each accepted request is expanded into the expected write-strobe sequence
// against a private copy of the display shadow. Every output transaction is
// compared field by field with the oldest expected bit. The mismatch count
// and the number of bits still owed go back to the testbench top.
module segment_lcd_serial_writer_checker
  import seglcd_pkg::*;
#(
  parameter int MEM_NIBBLES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic [0:0]  m_tuser,
  input  logic        m_tlast,
  output int          mismatches,
  output int          pending
);

  // Request fields, lowest bits last
  typedef struct packed {
    logic [2:0] fill;
    logic [5:0] glyph;
    logic       dot;
    logic [3:0] seg_high;
    logic [3:0] seg_low;
    logic [2:0] digit_pos;
    logic       icon_on;
    logic [1:0] icon_bit;
    logic [7:0] value;
    logic [4:0] address;
    logic [2:0] mode;
  } lcd_req_t;

  // One write strobe
  typedef struct packed {
    logic data_bit;
    logic frame_end;
    logic last;
  } strobe_bit_t;

  logic [3:0]  shadow_nib [MEM_NIBBLES];
  strobe_bit_t expected_bits [$];
  strobe_bit_t held_bit;
  logic        held_valid;
  strobe_bit_t want;

  // Segment pair {first nibble, second nibble} for glyphs up to blank
  function automatic logic [7:0] glyph_segments(input logic [5:0] g);
    case (g)
      6'd0:  return 8'hFA;
      6'd1:  return 8'h0A;
      6'd2:  return 8'hD6;
      6'd3:  return 8'h9E;
      6'd4:  return 8'h2E;
      6'd5:  return 8'hBC;
      6'd6:  return 8'hFC;
      6'd7:  return 8'h1A;
      6'd8:  return 8'hFE;
      6'd9:  return 8'hBE;
      6'd10: return 8'h7E;
      6'd11: return 8'hEC;
      6'd12: return 8'hF0;
      6'd13: return 8'hCE;
      6'd14: return 8'hF4;
      6'd15: return 8'h74;
      6'd16: return 8'hFC;
      6'd17: return 8'h6E;
      6'd18: return 8'h0A;
      6'd19: return 8'h8E;
      6'd20: return 8'h66;
      6'd21: return 8'hE0;
      6'd22: return 8'h5A;
      6'd23: return 8'h4C;
      6'd24: return 8'hFA;
      6'd25: return 8'h76;
      6'd26: return 8'h3E;
      6'd27: return 8'h44;
      6'd28: return 8'hBC;
      6'd29: return 8'hE4;
      6'd30: return 8'hC8;
      6'd31: return 8'hEA;
      6'd32: return 8'hCA;
      6'd33: return 8'h6A;
      6'd34: return 8'hBE;
      6'd35: return 8'h96;
      default: return 8'h00;
    endcase
  endfunction

  // Reads past the end of memory give zero
  function automatic logic [3:0] shadow_get(input logic [5:0] a);
    if (a < MEM_NIBBLES) return shadow_nib[a];
    return 4'h0;
  endfunction

  task automatic report(input string field, input logic exp_val, input logic got_val);
    if (mismatches < 40)
      $display("%0t: mismatch on %s, expected %0b got %0b", $time, field, exp_val, got_val);
    mismatches++;
  endtask

  // The newest bit is held back so the request's final one can be marked last
  task automatic emit_bit(input logic b, input logic fe);
    if (held_valid) expected_bits.push_back(held_bit);
    held_bit   = '{b, fe, 1'b0};
    held_valid = 1'b1;
  endtask

  task automatic queue_command(input logic [7:0] c);
    for (int i = 2; i >= 0; i--) emit_bit(ID_CMD[i], 1'b0);
    for (int i = 7; i >= 0; i--) emit_bit(c[i], 1'b0);
    emit_bit(1'b0, 1'b1);
  endtask

  // Write frame: ID, address MSB first, data LSB first; updates the shadow
  task automatic queue_write(input logic [5:0] a, input logic [3:0] nib);
    if (a < MEM_NIBBLES) shadow_nib[a] = nib;
    for (int i = 2; i >= 0; i--) emit_bit(ID_WRITE[i], 1'b0);
    for (int i = 5; i >= 0; i--) emit_bit(a[i], 1'b0);
    for (int i = 0; i < 4; i++) emit_bit(nib[i], i == 3);
  endtask

  // Two frames to a nibble pair; the icon bit is read before either write
  task automatic queue_digit(input logic [2:0] pos, input logic [3:0] s0,
                             input logic [3:0] s1, input logic dp);
    logic [5:0] a0;
    logic [3:0] old_nib;
    a0 = (pos < 3'd4) ? {2'b00, pos, 1'b0}
                      : LOWER_ROW_BASE + {2'b00, pos - 3'd4, 1'b0};
    old_nib = shadow_get(a0 + 6'd1);
    queue_write(a0, s0);
    queue_write(a0 + 6'd1, {s1[3:1], s1[0] | (dp ? 1'b1 : old_nib[0])});
  endtask

  task automatic predict_request(input lcd_req_t req);
    logic [3:0] nib;
    logic [7:0] pair;
    case (req.mode)
      MODE_CMD: queue_command(req.value);
      MODE_RAW: queue_write({1'b0, req.address}, req.value[3:0]);
      MODE_ICON: begin
        nib = shadow_get({1'b0, req.address});
        nib[req.icon_bit] = req.icon_on;
        queue_write({1'b0, req.address}, nib);
      end
      MODE_DIGIT: queue_digit(req.digit_pos, req.seg_low, req.seg_high, req.dot);
      MODE_GLYPH: begin
        if (req.glyph <= GLYPH_BLANK) begin
          pair = glyph_segments(req.glyph);
          queue_digit(req.digit_pos, pair[7:4], pair[3:0], 1'b0);
        end
      end
      default: ;
    endcase
    if (held_valid) begin
      held_bit.last = 1'b1;
      expected_bits.push_back(held_bit);
      held_valid = 1'b0;
    end
  endtask

  // Compare output transactions, then expand newly accepted requests
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MEM_NIBBLES; i++) shadow_nib[i] = 4'h0;
      expected_bits.delete();
      held_valid = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_bits.size() == 0) begin
          report("unexpected bit", 1'b0, m_tdata[0]);
        end else begin
          want = expected_bits.pop_front();
          if (m_tdata[0] !== want.data_bit) report("data_bit", want.data_bit, m_tdata[0]);
          if (m_tuser[0] !== want.frame_end) report("frame_end", want.frame_end, m_tuser[0]);
          if (m_tlast !== want.last) report("last", want.last, m_tlast);
        end
      end
      if (s_tvalid && s_tready) predict_request(lcd_req_t'(s_tdata));
    end
    pending = expected_bits.size();
  end

endmodule

// ===== verif/segment_lcd_serial_writer_top_tb.sv =====
// ----------------------------------------------------------------------------
// segment_lcd_serial_writer_top_tb
// Testbench for the segment LCD serial writer.
// ----------------------------------------------------------------------------
// A directed sequence covers every mode, field extremes, icon bit keeping,
// the dot override, blank and out-of-range glyphs and unused modes. Random
// requests follow in bursts with gaps, weighted toward the low addresses that
// digits share with icons. The output side stalls on a changing pattern. A
// separate checker predicts and compares; this module gives the verdict.
module segment_lcd_serial_writer_top_tb;
  import seglcd_pkg::*;

  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
  localparam logic [5:0] GLYPH_TOP        = 6'd63;
  localparam int         RANDOM_REQUESTS  = 380;
  localparam int         SETTLE_CYCLES    = 64;
  localparam int         RUN_LIMIT        = 500000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;
  int          mismatches;
  int          pending;
  int          cycle_count = 0;
  logic [15:0] sink_cycle  = '0;

  always #4 clk = ~clk;

  segment_lcd_serial_writer_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  segment_lcd_serial_writer_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Output side: full speed, random stalls, a fixed stall pattern, heavy stalls
  always @(posedge clk) begin
    sink_cycle <= sink_cycle + 16'd1;
    case (sink_cycle[10:9])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= ($urandom_range(0, 3) != 0);
      2'd2: m_tready <= (sink_cycle[2:0] != 3'd5) && (sink_cycle[2:0] != 3'd6);
      default: m_tready <= ($urandom_range(0, 2) == 0);
    endcase
  end

  function automatic logic [39:0] req_word(
    input logic [2:0] mode, input logic [4:0] addr, input logic [7:0] value,
    input logic [1:0] ibit, input logic ion, input logic [2:0] pos,
    input logic [3:0] s0, input logic [3:0] s1, input logic dp, input logic [5:0] glyph);
    return {3'b000, glyph, dp, s1, s0, pos, ion, ibit, value, addr, mode};
  endfunction

  function automatic logic [39:0] rand_req();
    logic [2:0] mode;
    logic [4:0] addr;
    logic [5:0] glyph;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 15)      mode = MODE_CMD;
    else if (pick < 30) mode = MODE_RAW;
    else if (pick < 50) mode = MODE_ICON;
    else if (pick < 70) mode = MODE_DIGIT;
    else if (pick < 94) mode = MODE_GLYPH;
    else                mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
    // favor the nibbles that digits and icons share
    addr  = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 20));
    glyph = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, GLYPH_TOP))
                                        : 6'($urandom_range(0, GLYPH_BLANK));
    return req_word(mode, addr, 8'($urandom), 2'($urandom), 1'($urandom), 3'($urandom),
                    4'($urandom), 4'($urandom), 1'($urandom), glyph);
  endfunction

  function automatic logic makes_bits(input logic [39:0] word);
    if (word[2:0] <= MODE_DIGIT) return 1'b1;
    if (word[2:0] == MODE_GLYPH) return word[36:31] <= GLYPH_BLANK;
    return 1'b0;
  endfunction

  // Called at a rising edge; returns at the edge that accepts the transaction
  task automatic send_req(input logic [39:0] word);
    logic ready_seen;
    s_tdata  <= word;
    s_tvalid <= 1'b1;
    ready_seen = 1'b0;
    while (!ready_seen) begin
      @(negedge clk);
      ready_seen = s_tready;
      @(posedge clk);
    end
  endtask

  task automatic hold_off(input int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    int          sent;
    int          burst;
    logic        drained;
    logic [39:0] word;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Commands: all ones, all zeros, a mixed pattern
    send_req(req_word(MODE_CMD, 5'd0, 8'hFF, 2'd0, 1'b0, 3'd0, 4'h0, 4'h0, 1'b0, 6'd0));
    send_req(req_word(MODE_CMD, 5'd31, 8'h00, 2'd3, 1'b1, 3'd7, 4'hF, 4'hF, 1'b1, 6'd63));
    send_req(req_word(MODE_CMD, 5'd10, 8'h5A, 2'd1, 1'b0, 3'd2, 4'h5, 4'hA, 1'b0, 6'd21));
    // Raw writes: upper value bits are dropped
    send_req(req_word(MODE_RAW, 5'd31, 8'hF3, 2'd0, 1'b0, 3'd0, 4'h0, 4'h0, 1'b0, 6'd0));
    send_req(req_word(MODE_RAW, 5'd0, 8'h0C, 2'd0, 1'b0, 3'd0, 4'h0, 4'h0, 1'b0, 6'd0));
    // Icon set and clear on top of stored data
    send_req(req_word(MODE_ICON, 5'd31, 8'h00, 2'd3, 1'b1, 3'd0, 4'h0, 4'h0, 1'b0, 6'd0));
    send_req(req_word(MODE_ICON, 5'd31, 8'hFF, 2'd0, 1'b0, 3'd0, 4'h0, 4'h0, 1'b0, 6'd0));
    send_req(req_word(MODE_ICON, 5'd1, 8'h00, 2'd0, 1'b1, 3'd0, 4'h0, 4'h0, 1'b0, 6'd0));
    // Digit keeps the icon bit set above, then dot override
    send_req(req_word(MODE_DIGIT, 5'd0, 8'h00, 2'd0, 1'b0, 3'd0, 4'hF, 4'hE, 1'b0, 6'd0));
    send_req(req_word(MODE_DIGIT, 5'd0, 8'h00, 2'd0, 1'b0, 3'd3, 4'h0, 4'h0, 1'b1, 6'd0));
    send_req(req_word(MODE_ICON, 5'd20, 8'h00, 2'd0, 1'b1, 3'd0, 4'h0, 4'h0, 1'b0, 6'd0));
    send_req(req_word(MODE_DIGIT, 5'd0, 8'h00, 2'd0, 1'b0, 3'd7, 4'h5, 4'hA, 1'b0, 6'd0));
    send_req(req_word(MODE_DIGIT, 5'd0, 8'h00, 2'd0, 1'b0, 3'd4, 4'hF, 4'hF, 1'b1, 6'd0));
    // Glyphs: first and last digit, first and last letter, blank
    send_req(req_word(MODE_GLYPH, 5'd0, 8'h00, 2'd0, 1'b0, 3'd1, 4'h0, 4'h0, 1'b1, 6'd0));
    send_req(req_word(MODE_GLYPH, 5'd0, 8'h00, 2'd0, 1'b0, 3'd5, 4'h0, 4'h0, 1'b0, 6'd9));
    send_req(req_word(MODE_GLYPH, 5'd0, 8'h00, 2'd0, 1'b0, 3'd2, 4'hF, 4'hF, 1'b0, 6'd10));
    send_req(req_word(MODE_GLYPH, 5'd0, 8'h00, 2'd0, 1'b0, 3'd6, 4'h0, 4'h0, 1'b1, 6'd35));
    send_req(req_word(MODE_GLYPH, 5'd0, 8'h00, 2'd0, 1'b0, 3'd7, 4'h0, 4'h0, 1'b0, GLYPH_BLANK));
    // Requests that produce nothing
    send_req(req_word(MODE_GLYPH, 5'd0, 8'h00, 2'd0, 1'b0, 3'd0, 4'h0, 4'h0, 1'b0, 6'd37));
    send_req(req_word(MODE_GLYPH, 5'd5, 8'hFF, 2'd3, 1'b1, 3'd3, 4'hF, 4'hF, 1'b1, GLYPH_TOP));
    send_req(req_word(MODE_SPARE_FIRST, 5'd3, 8'h12, 2'd1, 1'b1, 3'd1, 4'h3, 4'h4, 1'b1, 6'd2));
    send_req(req_word(MODE_SPARE_LAST, 5'd7, 8'h34, 2'd2, 1'b0, 3'd5, 4'h6, 4'h7, 1'b0, 6'd3));
    // Odd nibble written raw, then glyph over it
    send_req(req_word(MODE_RAW, 5'd16, 8'hFF, 2'd0, 1'b0, 3'd0, 4'h0, 4'h0, 1'b0, 6'd0));
    send_req(req_word(MODE_GLYPH, 5'd0, 8'h00, 2'd0, 1'b0, 3'd5, 4'h0, 4'h0, 1'b0, 6'd12));

    // Random bursts with gaps; one full drain half way through
    sent    = 0;
    drained = 1'b0;
    while (sent < RANDOM_REQUESTS) begin
      burst = $urandom_range(1, 16);
      repeat (burst) begin
        word = rand_req();
        send_req(word);
        if (makes_bits(word)) sent++;
      end
      if (!drained && sent >= RANDOM_REQUESTS / 2) begin
        wait_drained();
        drained = 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        hold_off($urandom_range(1, 24));
      end
    end
    s_tvalid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/seglcd_pkg.sv
rtl/seglcd_front.sv
rtl/seglcd_queue.sv
rtl/seglcd_serializer.sv
rtl/segment_lcd_serial_writer_top.sv
verif/segment_lcd_serial_writer_checker.sv
verif/segment_lcd_serial_writer_top_tb.sv
